### hw/rtl/kalman_tilt_angle_filter_assert.svh
// assertion macros for the tilt filter checker
// no dependencies
`ifndef KALMAN_TILT_ANGLE_FILTER_ASSERT_SVH
`define KALMAN_TILT_ANGLE_FILTER_ASSERT_SVH
`define KTF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hw/rtl/ktf_pkg.sv
// package for the tilt angle filter: payload types, constants, helpers
// no dependencies
package ktf_pkg;
    localparam int FRAC_BITS_DEF = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_DT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QG = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R  = 2'd3;

    typedef struct packed {
        logic signed [15:0] measured_angle;
        logic signed [15:0] angular_rate;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] filtered_angle;
        logic signed [15:0] rate_bias;
    } t_out_beat;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_PRED_A, OP_PRED_P0, OP_PRED_P1, OP_PRED_P3,
        OP_GAIN_E, OP_DIV_K0, OP_DIV_K1, OP_UPD_P0, OP_UPD_P1, OP_UPD_P2,
        OP_UPD_P3, OP_UPD_ERR, OP_UPD_A, OP_UPD_B
    } t_op;

    typedef struct packed {
        t_op  op;
        logic mul_go;
        logic div_go;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

### hw/rtl/ktf_datapath.sv
// datapath of the tilt filter: state, covariance, shared multiplier, serial divider
// depends on ktf_pkg
module ktf_datapath #(
    parameter int FRAC_BITS = ktf_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ktf_pkg::t_cmd          i_cmd,
    output ktf_pkg::t_sts          o_sts,
    input  ktf_pkg::t_in_beat      i_in,
    input  logic [23:0]            i_dt_raw,
    input  logic [23:0]            i_qa_raw,
    input  logic [23:0]            i_qg_raw,
    input  logic [23:0]            i_r_raw,
    output ktf_pkg::t_out_beat     o_out
);
    import ktf_pkg::*;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam int QW = 32 + FRAC_BITS + 1;
    localparam int CW = $clog2(QW + 1);

    logic signed [31:0] r_ang, r_bias, r_p0, r_p1, r_p2, r_p3;
    logic signed [31:0] r_meas, r_rate, r_e, r_k0, r_k1, r_t0, r_t1, r_err, r_tmp;
    logic signed [31:0] r_ma, r_mb, r_prod;
    logic               r_mul_done;
    logic [QW-1:0]      r_rem_n, r_quo;
    logic [32:0]        r_den;
    logic [QW:0]        r_rem;
    logic [CW-1:0]      r_cnt;
    logic               r_busy, r_div_done, r_neg, r_dz;
    logic signed [31:0] r_quo_q;

    function automatic logic signed [31:0] reg_q(input logic [23:0] raw);
        logic signed [65:0] v;
        v = 66'($unsigned(raw));
        if (FRAC_BITS >= 24) v = v <<< (FRAC_BITS - 24);
        else v = v >>> (24 - FRAC_BITS);
        return sat32(v);
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a, b);
        return sat32(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a, b);
        return sat32(66'(a) - 66'(b));
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [31:0] x, input int fb);
        logic signed [65:0] v;
        v = (66'(x) + (66'sd1 <<< (FRAC_BITS - fb - 1))) >>> (FRAC_BITS - fb);
        if (v > 66'sd32767) return 16'sh7fff;
        if (v < -66'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    logic signed [31:0] dt, qa, qg, rr;
    assign dt = reg_q(i_dt_raw);
    assign qa = reg_q(i_qa_raw);
    assign qg = reg_q(i_qg_raw);
    assign rr = reg_q(i_r_raw);

    // shared multiplier operand select
    logic signed [31:0] n_ma, n_mb;
    always_comb begin
        n_ma = r_k0;
        n_mb = r_t0;
        unique case (i_cmd.op)
            OP_PRED_A:  begin n_ma = qsub(r_rate, r_bias); n_mb = dt; end
            OP_PRED_P0: begin n_ma = qsub(qsub(qa, r_p1), r_p2); n_mb = dt; end
            OP_PRED_P1: begin n_ma = sat32(-66'(r_p3)); n_mb = dt; end
            OP_PRED_P3: begin n_ma = qg; n_mb = dt; end
            OP_UPD_P0:  begin n_ma = r_k0; n_mb = r_t0; end
            OP_UPD_P1:  begin n_ma = r_k0; n_mb = r_t1; end
            OP_UPD_P2:  begin n_ma = r_k1; n_mb = r_t0; end
            OP_UPD_P3:  begin n_ma = r_k1; n_mb = r_t1; end
            OP_UPD_A:   begin n_ma = r_k0; n_mb = r_err; end
            OP_UPD_B:   begin n_ma = r_k1; n_mb = r_err; end
            default:    ;
        endcase
    end

    // multiplier: operands registered, then rounded product registered
    logic signed [63:0] mul_full;
    logic signed [65:0] mul_rnd;
    logic               r_mul_stage;
    assign mul_full = r_ma * r_mb;
    assign mul_rnd = (66'(mul_full) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_stage <= 1'b0;
            r_mul_done <= 1'b0;
        end else begin
            r_mul_stage <= i_cmd.mul_go;
            r_mul_done <= r_mul_stage;
        end
        if (i_cmd.mul_go) begin
            r_ma <= n_ma;
            r_mb <= n_mb;
        end
        if (r_mul_stage) r_prod <= sat32(mul_rnd);
    end

    // restoring divider, one quotient bit per cycle
    logic signed [31:0] div_num, div_den;
    logic [31:0]        num_mag;
    logic [32:0]        den_mag;
    logic [QW:0]        trial;
    logic [65:0]        quo_ext;
    assign div_num = (i_cmd.op == OP_DIV_K1) ? r_p2 : r_p0;
    assign div_den = r_e;
    assign num_mag = div_num[31] ? 32'(-div_num) : 32'(div_num);
    assign den_mag = div_den[31] ? 33'(-33'(div_den)) : 33'(div_den);
    assign trial = {r_rem[QW-1:0], r_rem_n[QW-1]};
    assign quo_ext = 66'(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div_done <= 1'b0;
        end else begin
            r_div_done <= 1'b0;
            if (i_cmd.div_go) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(QW);
                r_rem <= '0;
                r_rem_n <= QW'({1'b0, num_mag}) << FRAC_BITS;
                r_quo <= '0;
                r_den <= den_mag;
                r_neg <= div_num[31] ^ div_den[31];
                r_dz <= (div_den == 32'sd0);
            end else if (r_busy) begin
                r_rem_n <= r_rem_n << 1;
                if (trial >= (QW+1)'(r_den)) begin
                    r_rem <= trial - (QW+1)'(r_den);
                    r_quo <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quo <= {r_quo[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_div_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_dz) r_quo_q = '0;
        else if (r_neg) r_quo_q = sat32(-66'(quo_ext));
        else r_quo_q = sat32(66'(quo_ext));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang <= '0;
            r_bias <= '0;
            r_p0 <= ONE;
            r_p1 <= '0;
            r_p2 <= '0;
            r_p3 <= ONE;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_meas <= sat32(66'(i_in.measured_angle) <<< (FRAC_BITS - 13));
                    r_rate <= sat32(66'(i_in.angular_rate) <<< (FRAC_BITS - 10));
                end
                OP_PRED_A:  if (r_mul_done) r_ang <= qadd(r_ang, r_prod);
                OP_PRED_P0: if (r_mul_done) r_p0 <= qadd(r_p0, r_prod);
                OP_PRED_P1: if (r_mul_done) begin
                    r_p1 <= qadd(r_p1, r_prod);
                    r_p2 <= qadd(r_p2, r_prod);
                end
                OP_PRED_P3: if (r_mul_done) r_p3 <= qadd(r_p3, r_prod);
                OP_GAIN_E: begin
                    r_e <= qadd(rr, r_p0);
                    r_t0 <= r_p0;
                    r_t1 <= r_p1;
                end
                OP_DIV_K0: if (r_div_done) r_k0 <= r_quo_q;
                OP_DIV_K1: if (r_div_done) r_k1 <= r_quo_q;
                OP_UPD_P0: if (r_mul_done) r_p0 <= qsub(r_p0, r_prod);
                OP_UPD_P1: if (r_mul_done) r_p1 <= qsub(r_p1, r_prod);
                OP_UPD_P2: if (r_mul_done) r_p2 <= qsub(r_p2, r_prod);
                OP_UPD_P3: if (r_mul_done) r_p3 <= qsub(r_p3, r_prod);
                OP_UPD_ERR: r_err <= qsub(r_meas, r_ang);
                OP_UPD_A:  if (r_mul_done) r_ang <= qadd(r_ang, r_prod);
                OP_UPD_B:  if (r_mul_done) begin
                    r_bias <= qadd(r_bias, r_prod);
                    r_tmp <= qadd(r_bias, r_prod);
                end
                default: ;
            endcase
        end
    end

    assign o_sts.mul_done = r_mul_done;
    assign o_sts.div_done = r_div_done;
    assign o_out.filtered_angle = to_out(r_ang, 13);
    assign o_out.rate_bias = to_out(r_tmp, 10);
endmodule

### hw/rtl/ktf_ctrl.sv
// sequencer of the tilt filter: steps the datapath through predict and update
// depends on ktf_pkg
module ktf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_out_load,
    output ktf_pkg::t_cmd o_cmd,
    input  ktf_pkg::t_sts i_sts
);
    import ktf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} t_state;

    t_state r_state;
    t_op    r_op;
    logic   r_mul_go, r_div_go, r_out_valid;

    function automatic logic is_div(input t_op op);
        return (op == OP_DIV_K0) || (op == OP_DIV_K1);
    endfunction

    function automatic logic is_mul(input t_op op);
        return !(is_div(op) || op == OP_LOAD || op == OP_GAIN_E || op == OP_UPD_ERR
                 || op == OP_NOP);
    endfunction

    logic accept;
    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= OP_NOP;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_op <= OP_LOAD;
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    if (is_mul(r_op)) begin
                        r_mul_go <= 1'b1;
                        r_state <= S_WAIT;
                    end else if (is_div(r_op)) begin
                        r_div_go <= 1'b1;
                        r_state <= S_WAIT;
                    end else if (r_op == OP_UPD_B) begin
                        r_state <= S_DONE;
                    end else begin
                        r_op <= t_op'(r_op + 1'b1);
                    end
                end
                S_WAIT: if ((is_mul(r_op) && i_sts.mul_done) ||
                            (is_div(r_op) && i_sts.div_done)) begin
                    if (r_op == OP_UPD_B) begin
                        r_state <= S_DONE;
                    end else begin
                        r_op <= t_op'(r_op + 1'b1);
                        r_state <= S_ISSUE;
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_op <= OP_NOP;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd.op = r_op;
    assign o_cmd.mul_go = r_mul_go;
    assign o_cmd.div_go = r_div_go;
    assign o_out_valid = r_out_valid;
    assign o_out_load = (r_state == S_DONE);
endmodule

### hw/rtl/kalman_tilt_angle_filter.sv
// Tilt angle Kalman filter: one accelerometer angle and one gyro rate per input beat give
// one beat with the filtered angle and the gyro bias. Each beat runs ten products on one
// shared two-stage multiplier, two quotients on a restoring divider that produces one of
// FRAC_BITS+33 bits per cycle, and the load, gain-denominator and error steps. Input and
// output are separated by the output register; the next input is taken once the sequencer
// is idle and no stalled result is waiting.
// depends on ktf_pkg, ktf_ctrl, ktf_datapath
module kalman_tilt_angle_filter #(
    parameter int FRAC_BITS = ktf_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ktf_pkg::t_in_beat                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ktf_pkg::t_out_beat                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [ktf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ktf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ktf_pkg::*;

    logic [23:0] r_dt, r_qa, r_qg, r_r;
    t_cmd        cmd;
    t_sts        sts;
    t_out_beat   dp_out, r_out;
    t_in_beat    r_in;
    logic        out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= 24'd83886;
            r_qa <= 24'd1678;
            r_qg <= 24'd5033165;
            r_r  <= 24'd8388608;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DT: r_dt <= i_cfg_data;
                REG_QA: r_qa <= i_cfg_data;
                REG_QG: r_qg <= i_cfg_data;
                REG_R:  r_r  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input beat captured at the accepting edge
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_in <= i_in_data;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= dp_out;
    end

    ktf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_load(out_load), .o_cmd(cmd), .i_sts(sts)
    );

    ktf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_in(r_in), .i_dt_raw(r_dt), .i_qa_raw(r_qa), .i_qg_raw(r_qg),
        .i_r_raw(r_r), .o_out(dp_out)
    );

    assign o_out_data = r_out;
endmodule

### hw/rtl/ktf_checker.sv
// port-level checker for the tilt filter, bound to the top level
// depends on ktf_pkg and kalman_tilt_angle_filter_assert.svh
`include "kalman_tilt_angle_filter_assert.svh"
module ktf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ktf_pkg::t_out_beat o_out_data
);
    `KTF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `KTF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))
    `KTF_ASSERT_IMPL(a_no_accept_when_full, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
endmodule

bind kalman_tilt_angle_filter ktf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
);

### bench/kalman_tilt_angle_filter_test.sv
// testbench for kalman_tilt_angle_filter: random and directed sensor beats, checked against
// an in-bench fixed point model of the angle/bias filter kept in a scoreboard class
// depends on ktf_pkg and the kalman_tilt_angle_filter rtl
`timescale 1ns / 1ps

module kalman_tilt_angle_filter_test;
    import ktf_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int SETTLE_CYCLES = 150;
    localparam int ONE_Q = 1 << 24;

    class tilt_scoreboard;
        logic [23:0] dt_raw, qa_raw, qg_raw, r_raw;
        int angle_est, bias_est;
        int cov [4];
        t_out_beat filtered_q [$];
        int errors;

        function new();
            dt_raw = 24'd83886;
            qa_raw = 24'd1678;
            qg_raw = 24'd5033165;
            r_raw = 24'd8388608;
            angle_est = 0;
            bias_est = 0;
            cov = '{ONE_Q, 0, 0, ONE_Q};
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DT: dt_raw = val;
                REG_QA: qa_raw = val;
                REG_QG: qg_raw = val;
                REG_R:  r_raw = val;
                default: ;
            endcase
        endfunction

        function int clip32(longint v);
            if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
            if (v < -longint'(64'sd2147483648)) return 32'sh80000000;
            return int'(v);
        endfunction

        function int fx_add(int a, int b);
            return clip32(longint'(a) + longint'(b));
        endfunction

        function int fx_sub(int a, int b);
            return clip32(longint'(a) - longint'(b));
        endfunction

        function int fx_mul(int a, int b);
            longint p;
            p = longint'(a) * longint'(b) + (longint'(1) <<< 23);
            return clip32(p >>> 24);
        endfunction

        function int fx_div(int num, int den);
            if (den == 0) return 0;
            return clip32((longint'(num) <<< 24) / longint'(den));
        endfunction

        function logic [15:0] round_out(int x, int d);
            longint v;
            v = (longint'(x) + (longint'(1) <<< (d - 1))) >>> d;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function void note_input(t_in_beat b);
            int meas, rate, dt, e, k0, k1, t0, t1, err, d0, d1;
            t_out_beat o;
            meas = int'(b.measured_angle) * (1 << 11);
            rate = int'(b.angular_rate) * (1 << 14);
            dt = int'({8'd0, dt_raw});
            angle_est = fx_add(angle_est, fx_mul(fx_sub(rate, bias_est), dt));
            d0 = fx_sub(fx_sub(int'({8'd0, qa_raw}), cov[1]), cov[2]);
            d1 = clip32(-longint'(cov[3]));
            cov[0] = fx_add(cov[0], fx_mul(d0, dt));
            cov[1] = fx_add(cov[1], fx_mul(d1, dt));
            cov[2] = fx_add(cov[2], fx_mul(d1, dt));
            cov[3] = fx_add(cov[3], fx_mul(int'({8'd0, qg_raw}), dt));
            e = fx_add(int'({8'd0, r_raw}), cov[0]);
            k0 = fx_div(cov[0], e);
            k1 = fx_div(cov[2], e);
            t0 = cov[0];
            t1 = cov[1];
            cov[0] = fx_sub(cov[0], fx_mul(k0, t0));
            cov[1] = fx_sub(cov[1], fx_mul(k0, t1));
            cov[2] = fx_sub(cov[2], fx_mul(k1, t0));
            cov[3] = fx_sub(cov[3], fx_mul(k1, t1));
            err = fx_sub(meas, angle_est);
            angle_est = fx_add(angle_est, fx_mul(k0, err));
            bias_est = fx_add(bias_est, fx_mul(k1, err));
            o.filtered_angle = round_out(angle_est, 11);
            o.rate_bias = round_out(bias_est, 14);
            filtered_q.push_back(o);
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (filtered_q.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
                return;
            end
            want = filtered_q.pop_front();
            if (got.filtered_angle !== want.filtered_angle) begin
                $display("%0t: filtered_angle expected %h actual %h", $time,
                         want.filtered_angle, got.filtered_angle);
                errors++;
            end
            if (got.rate_bias !== want.rate_bias) begin
                $display("%0t: rate_bias expected %h actual %h", $time,
                         want.rate_bias, got.rate_bias);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_beat i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_beat o_out_data;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_DT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tilt_scoreboard sb = new();
    int cycles = 0;
    bit steady_sender = 0;

    kalman_tilt_angle_filter dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("kalman_tilt_angle_filter_test: done, errors");
            $finish;
        end
    end

    // receiver: check at the edge, change stall at the falling edge
    initial begin
        int mode_left;
        bit calm;
        mode_left = 0;
        calm = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            @(negedge i_clk);
            if (mode_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 600);
            end
            mode_left--;
            if (calm) i_out_stall <= 1'b0;
            else if ($urandom_range(0, 99) < 4) i_out_stall <= 1'b1;
            else if (i_out_stall && $urandom_range(0, 99) < 85) i_out_stall <= 1'b1;
            else i_out_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    function automatic int gap_len();
        if (steady_sender) return 0;
        if ($urandom_range(0, 9) < 6) return $urandom_range(0, 2);
        if ($urandom_range(0, 9) < 8) return $urandom_range(3, 15);
        return $urandom_range(40, 300);
    endfunction

    task automatic send_beat(logic [15:0] ang, logic [15:0] rate);
        t_in_beat b;
        int g;
        b.measured_angle = ang;
        b.angular_rate = rate;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(b);
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_in_data <= t_in_beat'($urandom);
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_beats(int n);
        int base;
        logic [15:0] a, r;
        base = $urandom_range(0, 16000) - 8000;
        repeat (n) begin
            if ($urandom_range(0, 9) < 7) begin
                // slowly moving tilt with small noisy rate
                base = base + $urandom_range(0, 200) - 100;
                if (base > 30000 || base < -30000) base = 0;
                a = 16'(base + $urandom_range(0, 400) - 200);
                r = 16'($urandom_range(0, 4000) - 2000);
            end else begin
                a = 16'($urandom);
                r = 16'($urandom);
            end
            send_beat(a, r);
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] cfg_sets [6][4];
        cfg_sets = '{
            '{24'd83886, 24'd1678, 24'd5033165, 24'd8388608},
            '{24'd1, 24'd0, 24'd0, 24'd1},
            '{24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff},
            '{24'hffffff, 24'd0, 24'hffffff, 24'd0},
            '{24'd20000, 24'd5000, 24'd300000, 24'd2000000},
            '{24'd83886, 24'd1678, 24'd5033165, 24'd8388608}
        };
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        steady_sender = 1;
        send_beat(16'sh7fff, 16'sh7fff);
        send_beat(16'sh8000, 16'sh8000);
        send_beat(16'sh0000, 16'sh0000);
        send_beat(16'sh7fff, 16'sh8000);
        send_beat(16'sh8000, 16'sh7fff);
        send_beat(16'sh0001, 16'shffff);
        send_beat(16'shffff, 16'sh0001);
        steady_sender = 0;
        send_beat(16'sh5555, 16'shaaaa);
        send_beat(16'shaaaa, 16'sh5555);
        send_beat(16'sh0000, 16'sh0000);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(REG_DT, cfg_sets[ph][0]);
            write_reg(REG_QA, cfg_sets[ph][1]);
            write_reg(REG_QG, cfg_sets[ph][2]);
            write_reg(REG_R, cfg_sets[ph][3]);
            steady_sender = (ph == 2);
            random_beats(200);
        end

        drain();
        if (sb.errors == 0) $display("kalman_tilt_angle_filter_test: done, clean");
        else $display("kalman_tilt_angle_filter_test: done, errors");
        $finish;
    end
endmodule
